### hdl/sorted_list_table_macros.svh
// Assertion macros used by the verification checker of the sorted list table.
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define SLT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_list_table: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define SLT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_list_table: next-cycle check failed");

`endif

### hdl/slt_pkg.sv
// Types, operation codes and defaults shared by the sorted list table modules.
package slt_pkg;

    // Default number of list entries.
    localparam int DEPTH_DEFAULT = 16;

    // Width of the entry count field in a result word.
    localparam int COUNT_FIELD_W = 5;

    // Operation codes carried in the kind field; code three is a no-op.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // Input word: one operation.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_in_word;

    // Output word: one result.
    typedef struct packed {
        logic                     hit;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic                     status;
    } t_out_word;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_FIND_RD,
        S_FIND_CMP,
        S_REM_RD,
        S_REM_WR,
        S_DONE
    } t_state;

    // Which neighbor of the index register the memory read addresses.
    typedef enum logic [1:0] {
        RD_CUR,
        RD_PREV,
        RD_NEXT
    } t_rd_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    idx_set_count;
        logic    idx_set_zero;
        logic    idx_inc;
        logic    idx_dec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        logic    wr_from_rd;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    hit_set;
        logic    full_set;
        logic    finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       idx_zero;
        logic       idx_at_end;
        logic       next_at_end;
        logic       full;
        logic       ge;
        logic       eq;
        logic       out_free;
    } t_dp_status;

endpackage

### hdl/sorted_list_table.sv
// Top level of the sorted list table: controller plus datapath.
//
// Keeps up to DEPTH signed 32-bit values in ascending order, duplicates allowed.
// Input channel (i_valid, o_ready, i_data) takes one word per operation: insert,
// search or remove. Output channel (o_valid, i_ready, o_data) returns one word per
// operation with the hit flag, the entry count after the operation and a status
// flag that marks an insert refused because the list was full.
// One operation is worked on at a time. The entries sit in a memory with one
// registered read port, so each entry visited takes a read state and then a
// compare or move state. An insert visits the entries greater or equal and the
// entry below them, if any; a search visits entries up to the first match, or
// all of them on a miss; a remove visits every entry whether it hits or not. A
// full insert or the unused code three goes straight to the result. The next
// word is accepted once the controller is back in idle after the previous
// result has been loaded into the output register, even while that result still
// waits for i_ready. When the receiver stalls, a finished operation waits until
// the register is free.
// Synchronous reset empties the list and drops any pending result; the memory
// itself is not cleared, since only written entries are ever read.
module sorted_list_table
    import slt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer.
    slt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Storage and compare logic.
    slt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

endmodule

### hdl/slt_ctrl.sv
// Controller state machine that sequences insert, search and remove scans.
module slt_ctrl
    import slt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_CUR;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.kind)
                    KIND_INSERT: begin
                        if (i_status.full) begin
                            o_cmd.full_set = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.idx_set_count = 1'b1;
                            n_state             = S_INS_RD;
                        end
                    end
                    KIND_SEARCH, KIND_REMOVE: begin
                        o_cmd.idx_set_zero = 1'b1;
                        n_state            = S_FIND_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // Walk down from the end, moving larger or equal entries up one place.
            S_INS_RD: begin
                if (i_status.idx_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_status.ge) begin
                    o_cmd.wr_from_rd = 1'b1;
                    o_cmd.idx_dec    = 1'b1;
                    n_state          = S_INS_RD;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end
            end
            // Walk up from the start looking for the first equal entry.
            S_FIND_RD: begin
                if (i_status.idx_at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_CUR;
                    n_state      = S_FIND_CMP;
                end
            end
            S_FIND_CMP: begin
                if (i_status.eq) begin
                    o_cmd.hit_set = 1'b1;
                    if (i_status.kind == KIND_REMOVE) begin
                        n_state = S_REM_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_FIND_RD;
                end
            end
            // Close the gap by moving every later entry down one place.
            S_REM_RD: begin
                if (i_status.next_at_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_REM_WR;
                end
            end
            S_REM_WR: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_from_rd = 1'b1;
                o_cmd.idx_inc    = 1'b1;
                n_state          = S_REM_RD;
            end
            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/slt_datapath.sv
// Datapath with the entry memory, scan index, entry count and result register.
module slt_datapath
    import slt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_word  o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]        mem [DEPTH];
    logic [1:0]         r_kind;
    logic signed [31:0] r_value;
    logic signed [31:0] r_rd_data;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_count;
    logic               r_hit;
    logic               r_full;
    t_out_word          r_out;
    logic               r_out_valid;

    logic [CW-1:0]      rd_ptr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [31:0]        count_ext;

    // Read address relative to the scan index.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: rd_ptr = r_idx - CW'(1);
            RD_NEXT: rd_ptr = r_idx + CW'(1);
            default: rd_ptr = r_idx;
        endcase
    end

    assign rd_addr = rd_ptr[AW-1:0];
    assign wr_addr = r_idx[AW-1:0];
    assign wr_data = i_cmd.wr_from_rd ? r_rd_data : r_value;

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Latched operation and result flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_data.kind;
            r_value <= i_data.value;
            r_hit   <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            if (i_cmd.hit_set) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.full_set) begin
                r_full <= 1'b1;
            end
        end
    end

    // Scan index and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.idx_set_count) begin
                r_idx <= r_count;
            end else if (i_cmd.idx_set_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - CW'(1);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // The count field carries the low bits of the entry count.
    assign count_ext = 32'(r_count);

    // Result register: holds a finished word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.hit         <= r_hit;
            r_out.entry_count <= count_ext[COUNT_FIELD_W-1:0];
            r_out.status      <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Status for the controller.
    always_comb begin
        o_status.kind        = r_kind;
        o_status.idx_zero    = (r_idx == '0);
        o_status.idx_at_end  = (r_idx == r_count);
        o_status.next_at_end = ((r_idx + CW'(1)) == r_count);
        o_status.full        = (r_count == CW'(DEPTH));
        o_status.ge          = (r_rd_data >= r_value);
        o_status.eq          = (r_rd_data == r_value);
        o_status.out_free    = !r_out_valid || i_ready;
    end

endmodule

### hdl/slt_checker.sv
// Port-level assertion checker for the sorted list table, bound to the top level.
`include "sorted_list_table_macros.svh"

module slt_checker
    import slt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    // A stalled result word holds its value.
    `SLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))

    // Only one operation is in flight: ready drops right after an accepted word.
    `SLT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // The reported count never exceeds the list size.
    `SLT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, o_valid, 32'(o_data.entry_count) <= DEPTH)

    // A refused insert never reports a hit.
    `SLT_ASSERT_IMP(a_full_no_hit, i_clk, i_rst_n, o_valid && o_data.status, !o_data.hit)

endmodule

bind sorted_list_table slt_checker #(.DEPTH(DEPTH)) u_slt_checker (.*);

### dv/tb_sorted_list_table.sv
// Self-checking testbench for the sorted list table: predicted results checked word by word.
`timescale 1ns / 1ps

module tb_sorted_list_table;
    import slt_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;

    // Kind code three carries no operation.
    localparam logic [1:0] KIND_NOP = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_data = '0;
    logic      out_ready = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_word o_data;

    // Shadow copy of the list, smallest entry first.
    logic signed [31:0] list_shadow [LIST_DEPTH];
    int                 list_len = 0;

    t_out_word pending_results [$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    sorted_list_table #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (o_ready),
        .i_data  (in_data),
        .o_valid (o_valid),
        .i_ready (out_ready),
        .o_data  (o_data)
    );

    // Free-running 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Position of the first entry equal to the value, or the list length if absent.
    function automatic int find_first(input logic signed [31:0] value);
        int pos;
        pos = 0;
        while (pos < list_len && list_shadow[pos] != value) pos++;
        return pos;
    endfunction

    // Applies one operation to the shadow list and returns the word it should produce.
    function automatic t_out_word predict_list_op(input logic [1:0] kind,
                                                  input logic signed [31:0] value);
        t_out_word res;
        int        pos;
        res = '0;
        pos = 0;
        case (kind)
            KIND_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    while (pos < list_len && list_shadow[pos] < value) pos++;
                    for (int i = list_len; i > pos; i--) list_shadow[i] = list_shadow[i-1];
                    list_shadow[pos] = value;
                    list_len++;
                end
            end
            KIND_SEARCH: begin
                res.hit = (find_first(value) < list_len);
            end
            KIND_REMOVE: begin
                pos = find_first(value);
                if (pos < list_len) begin
                    for (int i = pos; i + 1 < list_len; i++) list_shadow[i] = list_shadow[i+1];
                    list_len--;
                    res.hit = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = list_len[COUNT_FIELD_W-1:0];
        return res;
    endfunction

    // Sends one word, with an optional idle gap first, and records its expected result.
    task automatic send_word(input logic [1:0] kind, input logic signed [31:0] value);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= '{kind: kind, value: value};
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_list_op(kind, value));
    endtask

    // Holds the sender off until every expected word has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input int exp_val, input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Receiver side: random stalls on the output channel.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_data);
                fail_count++;
            end else begin
                exp_word = pending_results.pop_front();
                check_field("hit", int'(exp_word.hit), 32'(o_data.hit));
                check_field("entry_count", int'(exp_word.entry_count),
                            32'(o_data.entry_count));
                check_field("status", int'(exp_word.status), 32'(o_data.status));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Search and remove on an empty list.
    task automatic test_empty_list();
        send_word(KIND_SEARCH, 32'sd5);
        send_word(KIND_REMOVE, -32'sd5);
    endtask

    // Extreme values, signed ordering, duplicates, absent values and the unused code.
    task automatic test_extremes_and_order();
        send_word(KIND_INSERT, 32'sh7FFFFFFF);
        send_word(KIND_INSERT, 32'sh80000000);
        send_word(KIND_INSERT, 32'sd0);
        send_word(KIND_INSERT, 32'sd0);
        send_word(KIND_INSERT, -32'sd1);
        send_word(KIND_SEARCH, 32'sh80000000);
        send_word(KIND_REMOVE, 32'sd0);
        send_word(KIND_SEARCH, 32'sd0);
        send_word(KIND_REMOVE, 32'sd7);
        send_word(KIND_NOP, 32'shFFFFFFFF);
    endtask

    // Fill the list, then an insert into the full store is refused.
    task automatic test_full_store();
        while (list_len < LIST_DEPTH) send_word(KIND_INSERT, $urandom());
        send_word(KIND_INSERT, 32'sd1);
    endtask

    // Random operations with values mostly drawn from the list or a small pool.
    task automatic test_random_traffic(input int num_words, input int idle_pct,
                                       input int stall_pct, input int insert_weight,
                                       input bit pause_midway);
        logic [1:0]         kind;
        logic signed [31:0] value;
        int                 pick;
        int                 small_val;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < num_words; n++) begin
            if (pause_midway && n == num_words / 2) wait_for_results();
            pick = $urandom_range(99);
            if (pick < insert_weight) kind = KIND_INSERT;
            else if (pick < insert_weight + 25) kind = KIND_SEARCH;
            else if (pick < 96) kind = KIND_REMOVE;
            else kind = KIND_NOP;
            pick = $urandom_range(99);
            small_val = $urandom_range(6);
            if (pick < 55 && list_len > 0) value = list_shadow[$urandom_range(list_len - 1)];
            else if (pick < 82) value = small_val - 3;
            else if (pick < 88) value = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            else value = $urandom();
            send_word(kind, value);
        end
    endtask

    // Test sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_extremes_and_order();
        test_full_store();
        test_random_traffic(100, 0, 0, 45, 1'b0);
        test_random_traffic(100, 57, 0, 55, 1'b1);
        test_random_traffic(100, 0, 57, 35, 1'b0);
        test_random_traffic(100, 23, 23, 45, 1'b1);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
